[hdl/viterbi_best_derivation_update_core_assert.svh]
// Assertion macros shared by the best-derivation update core.
`ifndef VITERBI_BEST_DERIVATION_UPDATE_CORE_ASSERT_SVH
`define VITERBI_BEST_DERIVATION_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VBDU_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vbdu: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VBDU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vbdu: next-cycle check failed");

`endif

[hdl/vbdu_pkg.sv]
// Package: command and kind codes, sequencer states and default sizes.
package vbdu_pkg;

   localparam int IDX_BITS             = 6;
   localparam int CMD_BITS             = 3;
   localparam int KIND_BITS            = 2;
   localparam int TUSER_BITS           = CMD_BITS + KIND_BITS;

   localparam int DEF_MAX_ANNOTATIONS  = 64;
   localparam int DEF_SCORE_BITS       = 32;
   localparam int DEF_DAUGHTER_ID_BITS = 16;

   localparam logic [CMD_BITS-1:0] CMD_LOAD_LEFT  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_RIGHT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR      = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_TERM       = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_READ       = 3'd4;

   localparam logic [KIND_BITS-1:0] KIND_LEXICAL = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_UNARY   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BINARY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ADD_LEFT,
      ST_ADD_RIGHT,
      ST_UPDATE,
      ST_DRAIN
   } vbdu_state_type;

endpackage

[hdl/viterbi_best_derivation_update_core.sv]
// Top level: best-derivation table of one chart cell, max-plus update with argmax.
//
// Each request transaction carries one command: load a left or right daughter
// score (with its valid bit), clear the best table, offer a rule term, or read
// an entry; every command returns exactly one response transaction holding the
// entry at parent_index after the command. Scores are signed Q15.16 and sums
// saturate at the signed limits. From acceptance to the response register a
// transaction passes the registered memory read at the latched indices, one
// saturating addition per daughter, the compare and write-back, and the load
// of the response register, which waits while the response side stalls; the
// next request is taken only after that load. Only one transaction is in
// flight, so a write-back always lands before the next read and no
// forwarding is needed.
// Left, right and best tables are synchronous memories; the valid bits of the
// daughter vectors and the per-entry "present" bits of the best table are
// flip-flops cleared by reset, and a clear command drops all present bits at
// once, so there is no clearing pass. An entry whose present bit is low
// reads as the empty value (most negative score, zero ids).
module viterbi_best_derivation_update_core #(
   parameter int MAX_ANNOTATIONS  = vbdu_pkg::DEF_MAX_ANNOTATIONS,
   parameter int SCORE_BITS       = vbdu_pkg::DEF_SCORE_BITS,
   parameter int DAUGHTER_ID_BITS = vbdu_pkg::DEF_DAUGHTER_ID_BITS,
   localparam int REQ_RAW_BITS    = 3 * vbdu_pkg::IDX_BITS + SCORE_BITS + 1 + DAUGHTER_ID_BITS,
   localparam int REQ_BITS        = ((REQ_RAW_BITS + 7) / 8) * 8,
   localparam int RSP_RAW_BITS    = SCORE_BITS + DAUGHTER_ID_BITS + 2 * vbdu_pkg::IDX_BITS + 2,
   localparam int RSP_BITS        = ((RSP_RAW_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // parent_index, left_child_index, right_child_index, score_value,
   // valid_flag, daughter_id (lowest bits first), zero padded
   input  logic [REQ_BITS-1:0]               req_tdata,
   // command, kind (lowest bits first)
   input  logic [vbdu_pkg::TUSER_BITS-1:0]   req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // best_score, best_daughter, best_left, best_right, has_best, improved
   // (lowest bits first), zero padded
   output logic [RSP_BITS-1:0]               rsp_tdata
);
   import vbdu_pkg::*;

   localparam int ADDR_W    = (MAX_ANNOTATIONS > 1) ? $clog2(MAX_ANNOTATIONS) : 1;
   localparam int ENTRY_W   = SCORE_BITS + DAUGHTER_ID_BITS + 2 * IDX_BITS;
   // entry layout: score, daughter id, left index, right index (lowest first)
   localparam int E_DID_LO  = SCORE_BITS;
   localparam int E_LEFT_LO = SCORE_BITS + DAUGHTER_ID_BITS;
   localparam int E_RGHT_LO = E_LEFT_LO + IDX_BITS;
   // response layout offsets
   localparam int R_HAS     = ENTRY_W;
   localparam int R_IMP     = ENTRY_W + 1;
   // request layout offsets
   localparam int Q_SCORE   = 3 * IDX_BITS;
   localparam int Q_VALID   = Q_SCORE + SCORE_BITS;
   localparam int Q_DID     = Q_VALID + 1;

   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

   // saturating signed add at SCORE_BITS
   function automatic logic signed [SCORE_BITS-1:0] sat_add(
      input logic signed [SCORE_BITS-1:0] a,
      input logic signed [SCORE_BITS-1:0] b
   );
      logic signed [SCORE_BITS:0] s;
      s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
      if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
         return s[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
      end
      return s[SCORE_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Sequencer and latched transaction
   // ---------------------------------------------------------------------
   vbdu_state_type state_ff, state_in;

   logic [CMD_BITS-1:0]          cmd_ff;
   logic [KIND_BITS-1:0]         kind_ff;
   logic [IDX_BITS-1:0]          p_ff, j_ff, k_ff;
   logic signed [SCORE_BITS-1:0] score_ff;
   logic                         vflag_ff;
   logic [DAUGHTER_ID_BITS-1:0]  did_ff;

   logic                         req_fire;
   logic                         rsp_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // take the finished result when the response register is free or being emptied
   assign rsp_load   = (state_ff == ST_DRAIN) && (!rsp_tvalid || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_READ;
         ST_READ:      state_in = ST_ADD_LEFT;
         ST_ADD_LEFT:  state_in = ST_ADD_RIGHT;
         ST_ADD_RIGHT: state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_DRAIN;
         ST_DRAIN:     if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // hold the transaction fields for the whole read-modify-write
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tuser[CMD_BITS-1:0];
         kind_ff  <= req_tuser[CMD_BITS +: KIND_BITS];
         p_ff     <= req_tdata[0 +: IDX_BITS];
         j_ff     <= req_tdata[IDX_BITS +: IDX_BITS];
         k_ff     <= req_tdata[2*IDX_BITS +: IDX_BITS];
         score_ff <= req_tdata[Q_SCORE +: SCORE_BITS];
         vflag_ff <= req_tdata[Q_VALID];
         did_ff   <= req_tdata[Q_DID +: DAUGHTER_ID_BITS];
      end
   end

   logic [ADDR_W-1:0] p_addr, j_addr, k_addr;
   logic              p_ok, j_ok, k_ok;

   assign p_addr = ADDR_W'(p_ff);
   assign j_addr = ADDR_W'(j_ff);
   assign k_addr = ADDR_W'(k_ff);
   assign p_ok   = int'(p_ff) < MAX_ANNOTATIONS;
   assign j_ok   = int'(j_ff) < MAX_ANNOTATIONS;
   assign k_ok   = int'(k_ff) < MAX_ANNOTATIONS;

   // ---------------------------------------------------------------------
   // Memories and valid bits
   // ---------------------------------------------------------------------
   logic [SCORE_BITS-1:0] left_mem  [MAX_ANNOTATIONS];
   logic [SCORE_BITS-1:0] right_mem [MAX_ANNOTATIONS];
   logic [ENTRY_W-1:0]    best_mem  [MAX_ANNOTATIONS];

   logic signed [SCORE_BITS-1:0] left_rd_ff, right_rd_ff;
   logic [ENTRY_W-1:0]           best_rd_ff;

   logic [MAX_ANNOTATIONS-1:0] left_valid_ff, right_valid_ff, best_valid_ff;

   logic left_we, right_we, best_we, best_clear;
   logic [ENTRY_W-1:0] best_wdata;

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[p_addr] <= score_ff;
      end
      left_rd_ff <= left_mem[j_addr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[p_addr] <= score_ff;
      end
      right_rd_ff <= right_mem[k_addr];
   end

   always_ff @(posedge clock) begin
      if (best_we) begin
         best_mem[p_addr] <= best_wdata;
      end
      best_rd_ff <= best_mem[p_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_valid_ff  <= '0;
         right_valid_ff <= '0;
         best_valid_ff  <= '0;
      end else begin
         if (left_we)    left_valid_ff[p_addr]  <= vflag_ff;
         if (right_we)   right_valid_ff[p_addr] <= vflag_ff;
         if (best_clear) best_valid_ff          <= '0;
         else if (best_we) best_valid_ff[p_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Saturating sum in the add-left and add-right states
   // ---------------------------------------------------------------------
   logic signed [SCORE_BITS-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD_LEFT) begin
         sum_ff <= (kind_ff == KIND_LEXICAL) ? score_ff : sat_add(score_ff, left_rd_ff);
      end else if (state_ff == ST_ADD_RIGHT && kind_ff == KIND_BINARY) begin
         sum_ff <= sat_add(sum_ff, right_rd_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Compare, write back, build the result
   // ---------------------------------------------------------------------
   logic                         best_hit;
   logic signed [SCORE_BITS-1:0] cur_score;
   logic [DAUGHTER_ID_BITS-1:0]  cur_did;
   logic [IDX_BITS-1:0]          cur_left, cur_right, new_left, new_right;
   logic                         kind_ok, term_ok, improve;
   logic [RSP_BITS-1:0]          res_in, res_ff;

   // an entry without its present bit reads as empty
   assign best_hit  = p_ok && best_valid_ff[p_addr];
   assign cur_score = best_hit ? best_rd_ff[0 +: SCORE_BITS] : SCORE_MIN;
   assign cur_did   = best_hit ? best_rd_ff[E_DID_LO +: DAUGHTER_ID_BITS] : '0;
   assign cur_left  = best_hit ? best_rd_ff[E_LEFT_LO +: IDX_BITS] : '0;
   assign cur_right = best_hit ? best_rd_ff[E_RGHT_LO +: IDX_BITS] : '0;

   always_comb begin
      unique case (kind_ff)
         KIND_LEXICAL: kind_ok = 1'b1;
         KIND_UNARY:   kind_ok = j_ok && left_valid_ff[j_addr];
         KIND_BINARY:  kind_ok = j_ok && left_valid_ff[j_addr] && k_ok && right_valid_ff[k_addr];
         default:      kind_ok = 1'b0;
      endcase
   end

   assign term_ok  = (cmd_ff == CMD_TERM) && p_ok && vflag_ff && kind_ok;
   assign improve  = term_ok && (sum_ff > cur_score);
   assign new_left  = (kind_ff == KIND_LEXICAL) ? cur_left : j_ff;
   assign new_right = (kind_ff == KIND_BINARY) ? k_ff : cur_right;
   assign best_wdata = {new_right, new_left, did_ff, sum_ff};

   // command decode for the write-back cycle
   always_comb begin
      left_we    = 1'b0;
      right_we   = 1'b0;
      best_clear = 1'b0;
      best_we    = 1'b0;
      if (state_ff == ST_UPDATE) begin
         unique case (cmd_ff)
            CMD_LOAD_LEFT:  left_we    = p_ok;
            CMD_LOAD_RIGHT: right_we   = p_ok;
            CMD_CLEAR:      best_clear = 1'b1;
            CMD_TERM:       best_we    = improve;
            default:        best_we    = 1'b0;
         endcase
      end
   end

   always_comb begin
      res_in = '0;
      if (improve) begin
         res_in[ENTRY_W-1:0] = best_wdata;
         res_in[R_HAS]       = 1'b1;
      end else if (cmd_ff != CMD_CLEAR) begin
         res_in[ENTRY_W-1:0] = {cur_right, cur_left, cur_did, cur_score};
         res_in[R_HAS]       = best_hit;
      end else begin
         // cleared entry: most negative score, everything else zero
         res_in[0 +: SCORE_BITS] = SCORE_MIN;
      end
      res_in[R_IMP] = improve;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         res_ff <= res_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic                rsp_tvalid_ff;
   logic [RSP_BITS-1:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
`include "viterbi_best_derivation_update_core_assert.svh"

   // a replaced entry must be present in the response
   `VBDU_ASSERT_IMPLIES(a_improved_has_best, rsp_tvalid && rsp_tdata[R_IMP], rsp_tdata[R_HAS])
   // a strict improvement can never store the most negative score
   `VBDU_ASSERT_IMPLIES(a_improve_above_min, best_we, sum_ff != SCORE_MIN)
   // a clear has emptied the whole table by the next cycle
   `VBDU_ASSERT_NEXT(a_clear_empties, best_clear, best_valid_ff == '0)
   // only a term can report a replacement
   `VBDU_ASSERT_IMPLIES(a_improve_only_term, (state_ff == ST_DRAIN) && res_ff[R_IMP], cmd_ff == CMD_TERM)

endmodule

[verif/vbdu_best_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the best-derivation core: predicts each entry report and compares responses.
module vbdu_best_table_checker
   import vbdu_pkg::*;
#(
   parameter int REQ_W = ((3 * IDX_BITS + DEF_SCORE_BITS + 1 + DEF_DAUGHTER_ID_BITS + 7) / 8) * 8,
   parameter int RSP_W = ((DEF_SCORE_BITS + DEF_DAUGHTER_ID_BITS + 2 * IDX_BITS + 2 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic [TUSER_BITS-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   output int unsigned           mismatch_count,
   output int unsigned           reports_pending
);

   localparam int N_ENTRIES = DEF_MAX_ANNOTATIONS;
   localparam logic signed [DEF_SCORE_BITS-1:0] SCORE_CEIL  = {1'b0, {(DEF_SCORE_BITS-1){1'b1}}};
   localparam logic signed [DEF_SCORE_BITS-1:0] SCORE_FLOOR = {1'b1, {(DEF_SCORE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [DEF_DAUGHTER_ID_BITS-1:0] daughter_id;
      logic                            valid_flag;
      logic [DEF_SCORE_BITS-1:0]       score;
      logic [IDX_BITS-1:0]             right_idx;
      logic [IDX_BITS-1:0]             left_idx;
      logic [IDX_BITS-1:0]             parent_idx;
   } request_word_t;

   typedef struct packed {
      logic                            improved;
      logic                            has_best;
      logic [IDX_BITS-1:0]             best_right;
      logic [IDX_BITS-1:0]             best_left;
      logic [DEF_DAUGHTER_ID_BITS-1:0] best_daughter;
      logic [DEF_SCORE_BITS-1:0]       best_score;
   } best_report_t;

   logic signed [DEF_SCORE_BITS-1:0] left_score  [N_ENTRIES];
   logic                             left_ok     [N_ENTRIES];
   logic signed [DEF_SCORE_BITS-1:0] right_score [N_ENTRIES];
   logic                             right_ok    [N_ENTRIES];
   logic signed [DEF_SCORE_BITS-1:0] best_score  [N_ENTRIES];
   logic [DEF_DAUGHTER_ID_BITS-1:0]  best_dtr    [N_ENTRIES];
   logic [IDX_BITS-1:0]              best_left   [N_ENTRIES];
   logic [IDX_BITS-1:0]              best_right  [N_ENTRIES];
   logic                             best_has    [N_ENTRIES];

   best_report_t expected_reports [$];
   int unsigned  fail_tally;

   function automatic logic signed [DEF_SCORE_BITS-1:0] sat_sum(
      logic signed [DEF_SCORE_BITS-1:0] a, logic signed [DEF_SCORE_BITS-1:0] b);
      logic signed [DEF_SCORE_BITS:0] s;
      s = a + b;
      if (s[DEF_SCORE_BITS] != s[DEF_SCORE_BITS-1])
         return s[DEF_SCORE_BITS] ? SCORE_FLOOR : SCORE_CEIL;
      return s[DEF_SCORE_BITS-1:0];
   endfunction

   function automatic void clear_best();
      for (int i = 0; i < N_ENTRIES; i++) begin
         best_score[i] = SCORE_FLOOR;
         best_dtr[i]   = '0;
         best_left[i]  = '0;
         best_right[i] = '0;
         best_has[i]   = 1'b0;
      end
   endfunction

   // Apply one command to the table copy and return the report of its parent entry.
   function automatic best_report_t apply_command(logic [CMD_BITS-1:0] cmd,
                                                  logic [KIND_BITS-1:0] kind,
                                                  request_word_t w);
      best_report_t                     rpt;
      logic signed [DEF_SCORE_BITS-1:0] total;
      logic                             usable;
      logic [IDX_BITS-1:0]              p;
      rpt = '0;
      p   = w.parent_idx;
      case (cmd)
         CMD_LOAD_LEFT: begin
            left_score[p] = w.score;
            left_ok[p]    = w.valid_flag;
         end
         CMD_LOAD_RIGHT: begin
            right_score[p] = w.score;
            right_ok[p]    = w.valid_flag;
         end
         CMD_CLEAR: clear_best();
         CMD_TERM: begin
            total  = w.score;
            usable = w.valid_flag &&
                     (kind == KIND_LEXICAL || kind == KIND_UNARY || kind == KIND_BINARY);
            if (kind == KIND_UNARY || kind == KIND_BINARY) begin
               usable = usable && left_ok[w.left_idx];
               total  = sat_sum(total, left_score[w.left_idx]);
            end
            if (kind == KIND_BINARY) begin
               usable = usable && right_ok[w.right_idx];
               total  = sat_sum(total, right_score[w.right_idx]);
            end
            // strictly greater only: a tie keeps the stored derivation
            if (usable && total > best_score[p]) begin
               best_score[p] = total;
               best_dtr[p]   = w.daughter_id;
               best_has[p]   = 1'b1;
               if (kind != KIND_LEXICAL) best_left[p] = w.left_idx;
               if (kind == KIND_BINARY) best_right[p] = w.right_idx;
               rpt.improved = 1'b1;
            end
         end
         default: ;
      endcase
      rpt.best_score    = best_score[p];
      rpt.best_daughter = best_dtr[p];
      rpt.best_left     = best_left[p];
      rpt.best_right    = best_right[p];
      rpt.has_best      = best_has[p];
      return rpt;
   endfunction

   task automatic check_field(string what, longint want, longint got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin : monitor
      best_report_t got;
      best_report_t want;
      if (reset) begin
         for (int i = 0; i < N_ENTRIES; i++) begin
            left_score[i]  = '0;
            left_ok[i]     = 1'b0;
            right_score[i] = '0;
            right_ok[i]    = 1'b0;
         end
         clear_best();
         expected_reports.delete();
         fail_tally = 0;
      end else begin
         // check the response first: a request taken on this edge cannot answer yet
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(best_report_t)-1:0];
            if (expected_reports.size() == 0) begin
               $display("%0t ns: response with nothing expected, actual %h", $time, got);
               fail_tally++;
            end else begin
               want = expected_reports.pop_front();
               check_field("best_score", longint'($signed(want.best_score)),
                           longint'($signed(got.best_score)));
               check_field("best_daughter", longint'(want.best_daughter),
                           longint'(got.best_daughter));
               check_field("best_left", longint'(want.best_left), longint'(got.best_left));
               check_field("best_right", longint'(want.best_right), longint'(got.best_right));
               check_field("has_best", longint'(want.has_best), longint'(got.has_best));
               check_field("improved", longint'(want.improved), longint'(got.improved));
            end
         end
         if (req_tvalid && req_tready)
            expected_reports.push_back(apply_command(req_tuser[CMD_BITS-1:0],
                                                     req_tuser[TUSER_BITS-1:CMD_BITS],
                                                     req_tdata[$bits(request_word_t)-1:0]));
      end
      mismatch_count  <= fail_tally;
      reports_pending <= expected_reports.size();
   end

endmodule

[verif/tb_viterbi_best_derivation_update_core.sv]
`timescale 1ns / 1ps
// Testbench top: drives command transactions into the best-derivation core and gives the verdict.
module tb_viterbi_best_derivation_update_core;
   import vbdu_pkg::*;

   localparam int REQ_W = ((3 * IDX_BITS + DEF_SCORE_BITS + 1 + DEF_DAUGHTER_ID_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((DEF_SCORE_BITS + DEF_DAUGHTER_ID_BITS + 2 * IDX_BITS + 2 + 7) / 8) * 8;
   localparam int REQ_USED = 3 * IDX_BITS + DEF_SCORE_BITS + 1 + DEF_DAUGHTER_ID_BITS;

   // codes the block has no use for: it must treat them as a read or a no-op
   localparam logic [CMD_BITS-1:0]  CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_BITS-1:0]  CMD_SPARE_HI = 3'd7;
   localparam logic [KIND_BITS-1:0] KIND_SPARE   = 2'd3;

   localparam logic signed [DEF_SCORE_BITS-1:0] SCORE_CEIL  = {1'b0, {(DEF_SCORE_BITS-1){1'b1}}};
   localparam logic signed [DEF_SCORE_BITS-1:0] SCORE_FLOOR = {1'b1, {(DEF_SCORE_BITS-1){1'b0}}};
   localparam logic [DEF_DAUGHTER_ID_BITS-1:0]  DTR_TOP     = '1;

   localparam int RANDOM_ITEMS  = 1350;
   localparam int DRAIN_EVERY   = 400;
   // one transaction in flight, and every response is drained before this settle time
   localparam int SETTLE_CYCLES = 24;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic [TUSER_BITS-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   int unsigned            mismatch_count;
   int unsigned            reports_pending;

   int                     burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   viterbi_best_derivation_update_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   vbdu_best_table_checker u_best_table_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   // Offer one command and hold it until the core takes it, then pace the next one.
   // Must be entered on a rising edge; tvalid is only ever raised here.
   task automatic offer_request(logic [CMD_BITS-1:0] cmd, logic [KIND_BITS-1:0] kind,
                                logic [IDX_BITS-1:0] par, logic [IDX_BITS-1:0] lft,
                                logic [IDX_BITS-1:0] rgt, logic [DEF_SCORE_BITS-1:0] score,
                                logic vld, logic [DEF_DAUGHTER_ID_BITS-1:0] dtr);
      logic [REQ_W-1:0] word;
      word               = '0;
      word[REQ_USED-1:0] = {dtr, vld, score, rgt, lft, par};
      req_tdata  <= word;
      req_tuser  <= {kind, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      // burst pacing: keep tvalid high within a burst, drop it for a random gap between
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // Hold the sender until the checker has seen every outstanding response.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_pending != 0);
   endtask

   // Mostly a handful of low indices so loads and terms meet; the rest spans the full range.
   function automatic logic [IDX_BITS-1:0] pick_index();
      if ($urandom_range(0, 9) < 7) return IDX_BITS'($urandom_range(0, 7));
      return IDX_BITS'($urandom_range(0, DEF_MAX_ANNOTATIONS - 1));
   endfunction

   // Small log scores dominate so that improvements stay frequent; extremes drive saturation.
   function automatic logic [DEF_SCORE_BITS-1:0] pick_score();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      if (sel < 75) return $urandom;
      if (sel < 87) return SCORE_CEIL - int'($urandom_range(0, 255));
      return SCORE_FLOOR + int'($urandom_range(0, 255));
   endfunction

   // One random command; returns 0 when the core would merely ignore it.
   task automatic random_request(output bit counted);
      logic [CMD_BITS-1:0]  cmd;
      logic [KIND_BITS-1:0] kind;
      int unsigned          sel;
      sel = $urandom_range(0, 99);
      if (sel < 15)      cmd = CMD_LOAD_LEFT;
      else if (sel < 30) cmd = CMD_LOAD_RIGHT;
      else if (sel < 84) cmd = CMD_TERM;
      else if (sel < 94) cmd = CMD_READ;
      else if (sel < 96) cmd = CMD_CLEAR;
      else               cmd = CMD_BITS'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      if ($urandom_range(0, 99) < 3) kind = KIND_SPARE;
      else                           kind = KIND_BITS'($urandom_range(KIND_LEXICAL, KIND_BINARY));
      offer_request(cmd, kind, pick_index(), pick_index(), pick_index(), pick_score(),
                    $urandom_range(0, 9) != 0,
                    DEF_DAUGHTER_ID_BITS'($urandom_range(0, 16'hFFFF)));
      counted = (cmd <= CMD_READ) && !(cmd == CMD_TERM && kind == KIND_SPARE);
   endtask

   // Receiver: random short stalls, a recurring stall-free window, and one
   // long hold-off so the core fills up and back-pressures the request side.
   initial begin : response_sink
      int          stall_left;
      int unsigned cyc;
      int unsigned taken;
      bit          held;
      stall_left = 0;
      cyc        = 0;
      taken      = 0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (rsp_tvalid && rsp_tready) taken++;
         if (!held && taken >= 300) begin
            held       = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (cyc % 512 < 128) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      bit          counted;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty entries, ties, skips, saturation and the kept indices.
      offer_request(CMD_READ, KIND_LEXICAL, 0, 0, 0, 0, 1'b0, 0);
      // a lexical term at the most negative score only ties with an empty entry
      offer_request(CMD_TERM, KIND_LEXICAL, 5, 0, 0, SCORE_FLOOR, 1'b1, 1);
      // valid flag low: skipped
      offer_request(CMD_TERM, KIND_LEXICAL, 6, 0, 0, 0, 1'b0, 1);
      offer_request(CMD_TERM, KIND_LEXICAL, 63, 63, 63, SCORE_CEIL, 1'b1, DTR_TOP);
      // equal total: no replacement
      offer_request(CMD_TERM, KIND_LEXICAL, 63, 0, 0, SCORE_CEIL, 1'b1, 7);
      offer_request(CMD_LOAD_LEFT, KIND_LEXICAL, 0, 0, 0, SCORE_CEIL, 1'b1, 0);
      offer_request(CMD_LOAD_LEFT, KIND_UNARY, 63, 0, 0, SCORE_FLOOR, 1'b1, 0);
      offer_request(CMD_LOAD_RIGHT, KIND_BINARY, 0, 0, 0, SCORE_FLOOR, 1'b1, 0);
      offer_request(CMD_LOAD_RIGHT, KIND_SPARE, 63, 0, 0, SCORE_CEIL, 1'b1, DTR_TOP);
      // unary sum saturates high
      offer_request(CMD_TERM, KIND_UNARY, 1, 0, 0, SCORE_CEIL, 1'b1, 2);
      // unary with a never-loaded left child: skipped
      offer_request(CMD_TERM, KIND_UNARY, 7, 10, 0, 0, 1'b1, 2);
      // binary sum saturates low and so only ties with the empty entry
      offer_request(CMD_TERM, KIND_BINARY, 2, 63, 0, SCORE_FLOOR, 1'b1, 3);
      offer_request(CMD_TERM, KIND_BINARY, 3, 0, 63, 0, 1'b1, 4);
      // binary with an invalid right child: skipped
      offer_request(CMD_TERM, KIND_BINARY, 4, 0, 20, 0, 1'b1, 5);
      // a load with valid low still writes the score but the child stays unusable
      offer_request(CMD_LOAD_LEFT, KIND_LEXICAL, 5, 0, 0, 100, 1'b0, 0);
      offer_request(CMD_TERM, KIND_UNARY, 8, 5, 0, 0, 1'b1, 6);
      offer_request(CMD_TERM, KIND_SPARE, 9, 0, 0, 5, 1'b1, 6);
      offer_request(CMD_TERM, KIND_LEXICAL, 4, 0, 0, 1000, 1'b1, 3);
      offer_request(CMD_TERM, KIND_LEXICAL, 4, 0, 0, 500, 1'b1, 4);
      // low left plus high right lands in range without saturating
      offer_request(CMD_TERM, KIND_BINARY, 4, 63, 63, 12345, 1'b1, 8);
      // lexical keeps both child indices, unary keeps the right one
      offer_request(CMD_TERM, KIND_LEXICAL, 4, 1, 1, 20000, 1'b1, 9);
      offer_request(CMD_TERM, KIND_UNARY, 4, 0, 2, -1, 1'b1, 10);
      for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
         offer_request(CMD_BITS'(c), KIND_LEXICAL, 4, 0, 0, 0, 1'b1, 0);
      offer_request(CMD_CLEAR, KIND_LEXICAL, 63, 0, 0, 0, 1'b0, 0);
      offer_request(CMD_READ, KIND_LEXICAL, 4, 0, 0, 0, 1'b0, 0);
      drain_responses();

      // Random part, with a full drain now and then.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_request(counted);
         if (counted) begin
            sent++;
            if (sent % DRAIN_EVERY == 0) drain_responses();
         end
      end
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && reports_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
